/* design/polygon_point_containment_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the polygon point containment unit
// Clocked concurrent checks, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef POLYGON_POINT_CONTAINMENT_UNIT_ASSERT_SVH
`define POLYGON_POINT_CONTAINMENT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check prop at every rising edge of clk while rstn is high
`define PPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// check prop at every rising edge of clk, reset included
`define PPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPC_ASSERT(lbl, clk, rstn, prop, msg)
`define PPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* design/ppc_pkg.sv */
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and codes of the polygon point containment unit.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int THICK_BITS    = 11;
  localparam int T2_BITS       = 2 * THICK_BITS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 11;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THICKNESS = 1'b0,
    CFG_FILL      = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic rotate;
    logic write;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic near;
    logic crossing;
    logic busy;
  } edge_res_t;

endpackage

/* design/ppc_cell.sv */
// ----------------------------------------------------------------------------
// ppc_cell
// One vertex cell of the rotating vertex ring.
// ----------------------------------------------------------------------------
module ppc_cell #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  ppc_pkg::cell_ctl_t            ctl,
  input  logic signed [COORD_BITS-1:0]  nbr_x,
  input  logic signed [COORD_BITS-1:0]  nbr_y,
  input  logic signed [COORD_BITS-1:0]  wr_x,
  input  logic signed [COORD_BITS-1:0]  wr_y,
  output logic signed [COORD_BITS-1:0]  x,
  output logic signed [COORD_BITS-1:0]  y
);

  logic signed [COORD_BITS-1:0] x_r, y_r;

  // load a new vertex, else take the neighbor's vertex on a rotate
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end else if (ctl.rotate) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

/* design/ppc_edge_eval.sv */
// ----------------------------------------------------------------------------
// ppc_edge_eval
// Five-stage edge test: outline band distance and strict ray crossing.
// ----------------------------------------------------------------------------
module ppc_edge_eval #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [COORD_BITS-1:0]     ax,
  input  logic signed [COORD_BITS-1:0]     ay,
  input  logic signed [COORD_BITS-1:0]     bx,
  input  logic signed [COORD_BITS-1:0]     by,
  input  logic signed [COORD_BITS-1:0]     px,
  input  logic signed [COORD_BITS-1:0]     py,
  input  logic signed [COORD_BITS:0]       rx,
  input  logic [ppc_pkg::T2_BITS-1:0]      t2,
  output ppc_pkg::edge_res_t               res
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 2;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int TW = ppc_pkg::T2_BITS;
  localparam int XW = 2 * SW + TW;

  // sign-extended operands
  logic signed [DW-1:0] axe, aye, bxe, bye, pxe, pye, rxe;
  assign axe = {{(DW-C){ax[C-1]}}, ax};
  assign aye = {{(DW-C){ay[C-1]}}, ay};
  assign bxe = {{(DW-C){bx[C-1]}}, bx};
  assign bye = {{(DW-C){by[C-1]}}, by};
  assign pxe = {{(DW-C){px[C-1]}}, px};
  assign pye = {{(DW-C){py[C-1]}}, py};
  assign rxe = {{(DW-C-1){rx[C]}}, rx};

  // stage 1: differences
  logic                 v1_r;
  logic signed [DW-1:0] ux_r, uy_r, wx_r, wy_r, vx_r, vy_r, rax_r;
  logic                 strad1_r, pxne1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    ux_r     <= axe - bxe;
    uy_r     <= aye - bye;
    wx_r     <= axe - pxe;
    wy_r     <= aye - pye;
    vx_r     <= bxe - pxe;
    vy_r     <= bye - pye;
    rax_r    <= rxe - axe;
    strad1_r <= ((ay > py) && (by < py)) || ((ay < py) && (by > py));
    pxne1_r  <= (pxe != rxe);
  end

  // stage 2: products
  logic                 v2_r, strad2_r, pxne2_r;
  logic signed [PW-1:0] pwx2_r, pwy2_r, pvx2_r, pvy2_r, pux2_r, puy2_r;
  logic signed [PW-1:0] pdx_r, pdy_r, pc1_r, pc2_r, pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pwx2_r   <= wx_r * wx_r;
    pwy2_r   <= wy_r * wy_r;
    pvx2_r   <= vx_r * vx_r;
    pvy2_r   <= vy_r * vy_r;
    pux2_r   <= ux_r * ux_r;
    puy2_r   <= uy_r * uy_r;
    pdx_r    <= ux_r * wx_r;
    pdy_r    <= uy_r * wy_r;
    pc1_r    <= ux_r * wy_r;
    pc2_r    <= uy_r * wx_r;
    pr_r     <= uy_r * rax_r;
    strad2_r <= strad1_r;
    pxne2_r  <= pxne1_r;
  end

  // stage 3: sums
  logic                 v3_r, strad3_r, pxne3_r;
  logic signed [SW-1:0] da_r, db_r, len2_r, dot_r, cross_r, d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    da_r     <= SW'(pwx2_r) + SW'(pwy2_r);
    db_r     <= SW'(pvx2_r) + SW'(pvy2_r);
    len2_r   <= SW'(pux2_r) + SW'(puy2_r);
    dot_r    <= SW'(pdx_r) + SW'(pdy_r);
    cross_r  <= SW'(pc1_r) - SW'(pc2_r);
    d1_r     <= SW'(pc1_r) + SW'(pr_r);
    strad3_r <= strad2_r;
    pxne3_r  <= pxne2_r;
  end

  // stage 4: band compares, squared perpendicular distance, crossing
  logic [SW-1:0]    ac;
  logic [XW-1:0]    ac_ext, t2_ext;
  logic             v4_r, near_ab_r, seg_ok_r, big_r, crs4_r;
  logic [2*SW-1:0]  acsq_r;
  logic [TW+SW-1:0] tl_r;

  assign ac     = cross_r[SW-1] ? SW'(-cross_r) : SW'(cross_r);
  assign ac_ext = {{(XW-SW){1'b0}}, ac};
  assign t2_ext = {{(XW-TW){1'b0}}, t2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    near_ab_r <= ({{(XW-SW){1'b0}}, da_r} <= t2_ext) ||
                 ({{(XW-SW){1'b0}}, db_r} <= t2_ext);
    seg_ok_r  <= (len2_r != '0) && !dot_r[SW-1] && (dot_r <= len2_r);
    big_r     <= (ac_ext[XW-1:32] != '0);
    acsq_r    <= ac * ac;
    tl_r      <= t2 * len2_r[SW-1:0];
    crs4_r    <= strad3_r && pxne3_r &&
                 (((d1_r > 0) && (cross_r < 0)) || ((d1_r < 0) && (cross_r > 0)));
  end

  // stage 5: final decision
  logic v5_r, near5_r, crs5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    near5_r <= near_ab_r || (seg_ok_r && !big_r &&
               ({{(XW-2*SW){1'b0}}, acsq_r} <= {{(XW-TW-SW){1'b0}}, tl_r}));
    crs5_r  <= crs4_r;
  end

  assign res.valid    = v5_r;
  assign res.near     = near5_r;
  assign res.crossing = crs5_r;
  assign res.busy     = v1_r | v2_r | v3_r | v4_r | v5_r;

endmodule

/* design/polygon_point_containment_unit.sv */
// ----------------------------------------------------------------------------
// polygon_point_containment_unit
// Vertex ring with a pipelined edge tester: outline band and even-odd fill.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | opcode, point_x, point_y
//  out_    | output    | out_valid / out_stall| status, on_outline, inside_res
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Clear and add transactions are accepted in idle and then handed off. A query
//  is accepted, then a full ring rotation feeds one edge a cycle into the
//  five-stage edge tester, the tester drains, and the result is handed off.
//  Reset (rst_n low, synchronous) empties the table and loads the register
//  defaults; no clearing pass. A stalled result holds in the output register
//  while the block goes back to idle and takes the next transaction.
// ----------------------------------------------------------------------------
`include "polygon_point_containment_unit_assert.svh"

module polygon_point_containment_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transactions
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic signed [COORD_BITS-1:0]         in_point_x,
  input  logic signed [COORD_BITS-1:0]         in_point_y,
  // result transactions
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_status,
  output logic                                 out_on_outline,
  output logic                                 out_inside_res,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ppc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int B_IDX = (MAX_VERTICES > 1) ? 1 : 0;
  localparam logic signed [C-1:0] COORD_MAX = {1'b0, {(C-1){1'b1}}};

  // configuration registers
  logic [ppc_pkg::THICK_BITS-1:0] thick_r;
  logic                           fill_r;
  logic [ppc_pkg::T2_BITS-1:0]    t2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= ppc_pkg::THICK_BITS'(1);
      fill_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (ppc_pkg::cfg_idx_t'(cfg_index))
        ppc_pkg::CFG_THICKNESS: thick_r <= cfg_data[ppc_pkg::THICK_BITS-1:0];
        ppc_pkg::CFG_FILL:      fill_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // squared thickness, settles long before a query reaches the compares
  always_ff @(posedge clk) begin
    t2_r <= thick_r * thick_r;
  end

  // control state
  ppc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   vcount_r, vcount_nxt;
  logic [CW-1:0]   step_r, step_nxt;
  logic signed [C-1:0] least_r, least_nxt;
  logic            onl_r, onl_nxt, par_r, par_nxt;
  logic            res_status_r, res_status_nxt;
  logic            res_onl_r, res_onl_nxt, res_ins_r, res_ins_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_status_r, out_onl_r, out_ins_r;
  logic signed [C-1:0] px_r, py_r, first_x_r, first_y_r;

  logic            in_acc, out_free, add_ok, issue;
  logic            rotate;
  ppc_pkg::opcode_t op;
  ppc_pkg::edge_res_t eres;

  assign in_stall = (state_r != ppc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign op       = ppc_pkg::opcode_t'(in_opcode);
  assign out_free = !out_valid_r || !out_stall;
  assign add_ok   = (vcount_r < CW'(MAX_VERTICES));
  assign rotate   = (state_r == ppc_pkg::ST_EVAL);
  assign issue    = rotate && (step_r < vcount_r);

  // vertex ring
  logic signed [C-1:0] cell_x [MAX_VERTICES];
  logic signed [C-1:0] cell_y [MAX_VERTICES];

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    localparam int NB = (k + 1 == MAX_VERTICES) ? 0 : k + 1;
    ppc_pkg::cell_ctl_t ctl;
    assign ctl.rotate = rotate;
    assign ctl.write  = in_acc && (op == ppc_pkg::OP_ADD) && add_ok &&
                        (vcount_r == CW'(k));
    ppc_cell #(.COORD_BITS(C)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .nbr_x (cell_x[NB]),
      .nbr_y (cell_y[NB]),
      .wr_x  (in_point_x),
      .wr_y  (in_point_y),
      .x     (cell_x[k]),
      .y     (cell_y[k])
    );
  end

  // edge endpoints: head cell and its neighbor, closing edge back to the first
  logic signed [C-1:0] bx_sel, by_sel;
  logic                last_edge;
  logic signed [C:0]   rx;

  assign last_edge = (step_r == vcount_r - CW'(1));
  assign bx_sel    = last_edge ? first_x_r : cell_x[B_IDX];
  assign by_sel    = last_edge ? first_y_r : cell_y[B_IDX];
  assign rx        = {least_r[C-1], least_r} - (C+1)'(1);

  ppc_edge_eval #(.COORD_BITS(C)) u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (issue),
    .ax     (cell_x[0]),
    .ay     (cell_y[0]),
    .bx     (bx_sel),
    .by     (by_sel),
    .px     (px_r),
    .py     (py_r),
    .rx     (rx),
    .t2     (t2_r),
    .res    (eres)
  );

  // hold the query point and first vertex for the whole rotation
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r      <= in_point_x;
      py_r      <= in_point_y;
      first_x_r <= cell_x[0];
      first_y_r <= cell_y[0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    step_nxt       = step_r;
    least_nxt      = least_r;
    onl_nxt        = onl_r;
    par_nxt        = par_r;
    res_status_nxt = res_status_r;
    res_onl_nxt    = res_onl_r;
    res_ins_nxt    = res_ins_r;

    // accumulate edge results as they leave the tester
    if (eres.valid) begin
      onl_nxt = onl_r | eres.near;
      par_nxt = par_r ^ eres.crossing;
    end

    case (state_r)
      ppc_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_status_nxt = 1'b0;
          res_onl_nxt    = 1'b0;
          res_ins_nxt    = 1'b0;
          state_nxt      = ppc_pkg::ST_FINISH;
          case (op)
            ppc_pkg::OP_CLEAR: begin
              vcount_nxt = '0;
              least_nxt  = COORD_MAX;
            end
            ppc_pkg::OP_ADD: begin
              if (add_ok) begin
                vcount_nxt = vcount_r + CW'(1);
                if (in_point_x < least_r) least_nxt = in_point_x;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            ppc_pkg::OP_QUERY: begin
              onl_nxt   = 1'b0;
              par_nxt   = 1'b0;
              step_nxt  = '0;
              state_nxt = ppc_pkg::ST_EVAL;
            end
            default: ;
          endcase
        end
      end
      ppc_pkg::ST_EVAL: begin
        // advance the ring one cell per cycle, full turn restores the order
        step_nxt = step_r + CW'(1);
        if (step_r == CW'(MAX_VERTICES - 1)) state_nxt = ppc_pkg::ST_DRAIN;
      end
      ppc_pkg::ST_DRAIN: begin
        if (!eres.busy) begin
          res_onl_nxt = onl_r;
          res_ins_nxt = onl_r | (fill_r & par_r);
          state_nxt   = ppc_pkg::ST_FINISH;
        end
      end
      ppc_pkg::ST_FINISH: begin
        if (out_free) state_nxt = ppc_pkg::ST_IDLE;
      end
      default: state_nxt = ppc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((state_r == ppc_pkg::ST_FINISH) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppc_pkg::ST_IDLE;
      vcount_r    <= '0;
      step_r      <= '0;
      least_r     <= COORD_MAX;
      onl_r       <= 1'b0;
      par_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      step_r      <= step_nxt;
      least_r     <= least_nxt;
      onl_r       <= onl_nxt;
      par_r       <= par_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_onl_r    <= res_onl_nxt;
    res_ins_r    <= res_ins_nxt;
    if ((state_r == ppc_pkg::ST_FINISH) && out_free) begin
      out_status_r <= res_status_r;
      out_onl_r    <= res_onl_r;
      out_ins_r    <= res_ins_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_on_outline = out_onl_r;
  assign out_inside_res = out_ins_r;

  // checks
  `PPC_ASSERT(a_count_bound, clk, rst_n, vcount_r <= CW'(MAX_VERTICES), "vertex count overflow")
  `PPC_ASSERT(a_eres_busy, clk, rst_n, eres.valid |-> (state_r == ppc_pkg::ST_EVAL || state_r == ppc_pkg::ST_DRAIN), "edge result outside a query")
  `PPC_ASSERT(a_add_count, clk, rst_n, (in_acc && op == ppc_pkg::OP_ADD && add_ok) |=> (vcount_r == $past(vcount_r) + CW'(1)), "add did not grow the table")
  `PPC_ASSERT(a_status_excl, clk, rst_n, (out_valid_r && out_status_r) |-> (!out_onl_r && !out_ins_r), "table full flag with a query answer")
  `PPC_ASSERT(a_inside_fill, clk, rst_n, (out_valid_r && out_ins_r && !out_onl_r) |-> fill_r, "interior answer without fill")

endmodule
